FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the classifier top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

FILE: hw/rtl/irfc_pkg.sv
// Package with types, constants and the tolerance window function of the IR classifier.
package irfc_pkg;
	localparam int DurW = 16;
	localparam int PctW = 7;
	localparam int IdxW = 7;
	localparam int NumFlags = 9;
	localparam logic [PctW-1:0] PctReset = 7'd30;
	localparam logic [DurW-1:0] MinTolReset = 16'd160;

	localparam logic [0:0] CfgPct = 1'b0;
	localparam logic [0:0] CfgMinTol = 1'b1;

	localparam int FRep = 0;
	localparam int FNec = 1;
	localparam int FSam = 2;
	localparam int FLg = 3;
	localparam int FS20 = 4;
	localparam int FS15 = 5;
	localparam int FS12 = 6;
	localparam int FPan = 7;
	localparam int FRc6 = 8;

	localparam logic [3:0] ProtoRaw = 4'd0;
	localparam logic [3:0] ProtoRep = 4'd1;
	localparam logic [3:0] ProtoNec = 4'd2;
	localparam logic [3:0] ProtoSam = 4'd3;
	localparam logic [3:0] ProtoLg = 4'd4;
	localparam logic [3:0] ProtoSony = 4'd5;
	localparam logic [3:0] ProtoPan = 4'd6;
	localparam logic [3:0] ProtoRc6 = 4'd7;
	localparam logic [3:0] ProtoRc5 = 4'd8;

	typedef struct packed {
		logic [3:0] protocol;
		logic [47:0] code_value;
		logic [5:0] bit_count;
		logic [6:0] confidence;
		logic decoded;
		logic repeat_frame;
	} result_t;

	typedef struct packed {
		logic [IdxW-1:0] index;
		logic [NumFlags-1:0] flags;
		logic [31:0] nec_value;
		logic [47:0] pan_value;
		logic [19:0] sony_value;
		logic [6:0] rc5_votes;
	} frame_t;

	// Window check: |d - target| within max(min_tol, target*pct/100), low edge clamped at 0.
	// Target is a constant, so target*pct is a narrow constant multiply.
	function automatic logic near_us(input logic [DurW-1:0] d, input logic [15:0] target,
			input logic [PctW-1:0] pct, input logic [DurW-1:0] min_tol);
		logic [23:0] prod;
		logic [43:0] scaled;
		logic [17:0] tol;
		logic [18:0] hi;
		logic [18:0] lo;
		prod = 24'(target) * 24'(pct);
		// Divide by 100 as a multiply by 2^26/100 rounded up; exact for prod below 1.8 million.
		scaled = 44'(prod) * 44'd671089;
		tol = 18'(scaled >> 26);
		if (tol < 18'(min_tol)) tol = 18'(min_tol);
		hi = 19'(target) + 19'(tol);
		lo = (19'(target) > 19'(tol)) ? 19'(target) - 19'(tol) : 19'd0;
		return (19'(d) >= lo) && (19'(d) <= hi);
	endfunction
endpackage

FILE: hw/rtl/irfc_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
interface irfc_item_if;
	logic valid;
	logic ready;
	logic [15:0] duration_us;
	logic last;
	modport source (output valid, duration_us, last, input ready);
	modport sink (input valid, duration_us, last, output ready);
endinterface

interface irfc_result_if;
	logic valid;
	logic ready;
	logic [3:0] protocol;
	logic [47:0] code_value;
	logic [5:0] bit_count;
	logic [6:0] confidence;
	logic decoded;
	logic repeat_frame;
	modport source (output valid, protocol, code_value, bit_count, confidence, decoded,
		repeat_frame, input ready);
	modport sink (input valid, protocol, code_value, bit_count, confidence, decoded,
		repeat_frame, output ready);
endinterface

interface irfc_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/irfc_check.sv
// Per-item candidate checks: next frame state from the current state and one duration.
module irfc_check (
	input logic [15:0] d,
	input logic [6:0] pct,
	input logic [15:0] min_tol,
	input irfc_pkg::frame_t cur,
	output irfc_pkg::frame_t nxt
);
	import irfc_pkg::*;

	logic [6:0] p;
	logic odd;
	logic [4:0] nec_bit;
	logic [5:0] pan_bit;
	logic [4:0] sony_bit;
	logic n_one, n_ok, p_one, p_ok, s_one, s_ok;

	assign p = cur.index;
	assign odd = p[0];
	assign nec_bit = 5'((p - 7'd3) >> 1);
	assign pan_bit = 6'((p - 7'd3) >> 1);
	assign sony_bit = 5'((p - 7'd2) >> 1);

	always_comb begin
		n_one = odd && near_us(d, 16'd1690, pct, min_tol);
		n_ok = odd ? (n_one || near_us(d, 16'd560, pct, min_tol))
			: near_us(d, 16'd560, pct, min_tol);
		p_one = odd && near_us(d, 16'd1290, pct, min_tol);
		p_ok = odd ? (p_one || near_us(d, 16'd430, pct, min_tol))
			: near_us(d, 16'd430, pct, min_tol);
		s_one = !odd && near_us(d, 16'd1200, pct, min_tol);
		s_ok = s_one || near_us(d, 16'd600, pct, min_tol);
	end

	always_comb begin
		nxt = cur;
		if (p < 7'd127) begin
			if (p == 7'd0) begin
				if (!near_us(d, 16'd9000, pct, min_tol)) begin
					nxt.flags[FRep] = 1'b0;
					nxt.flags[FNec] = 1'b0;
					nxt.flags[FLg] = 1'b0;
				end
				if (!near_us(d, 16'd4500, pct, min_tol)) nxt.flags[FSam] = 1'b0;
				if (!near_us(d, 16'd2400, pct, min_tol)) begin
					nxt.flags[FS20] = 1'b0;
					nxt.flags[FS15] = 1'b0;
					nxt.flags[FS12] = 1'b0;
				end
				if (!near_us(d, 16'd3500, pct, min_tol)) nxt.flags[FPan] = 1'b0;
				if (!near_us(d, 16'd2666, 7'd25, min_tol)) nxt.flags[FRc6] = 1'b0;
			end else if (p == 7'd1) begin
				if (!near_us(d, 16'd2250, pct, min_tol)) nxt.flags[FRep] = 1'b0;
				if (!near_us(d, 16'd4500, pct, min_tol)) begin
					nxt.flags[FNec] = 1'b0;
					nxt.flags[FSam] = 1'b0;
				end
				if (!near_us(d, 16'd4200, pct, min_tol)) nxt.flags[FLg] = 1'b0;
				if (!near_us(d, 16'd600, pct, min_tol)) begin
					nxt.flags[FS20] = 1'b0;
					nxt.flags[FS15] = 1'b0;
					nxt.flags[FS12] = 1'b0;
				end
				if (!near_us(d, 16'd1750, pct, min_tol)) nxt.flags[FPan] = 1'b0;
				if (!near_us(d, 16'd889, 7'd30, min_tol)) nxt.flags[FRc6] = 1'b0;
			end else begin
				if (p == 7'd2 && !near_us(d, 16'd560, pct, min_tol)) nxt.flags[FRep] = 1'b0;
				if (p < 7'd66) begin
					if (!n_ok) begin
						nxt.flags[FNec] = 1'b0;
						nxt.flags[FSam] = 1'b0;
						if (p < 7'd58) nxt.flags[FLg] = 1'b0;
					end
					if (n_one) nxt.nec_value[nec_bit] = 1'b1;
				end
				if (p < 7'd98) begin
					if (!p_ok) nxt.flags[FPan] = 1'b0;
					if (p_one) nxt.pan_value[pan_bit] = 1'b1;
				end
				if (p <= 7'd40) begin
					if (s_one && sony_bit < 5'd20) nxt.sony_value[sony_bit] = 1'b1;
					if (!s_ok) begin
						nxt.flags[FS20] = 1'b0;
						if (p <= 7'd30) nxt.flags[FS15] = 1'b0;
						if (p <= 7'd24) nxt.flags[FS12] = 1'b0;
					end
				end
			end
			if ((near_us(d, 16'd889, 7'd35, min_tol) || near_us(d, 16'd1778, 7'd35, min_tol))
					&& cur.rc5_votes < 7'd127)
				nxt.rc5_votes = cur.rc5_votes + 7'd1;
		end
		if (p < 7'd127) nxt.index = p + 7'd1;
	end
endmodule

FILE: hw/rtl/irfc_classify.sv
// Frame classification in priority order from the final frame state.
module irfc_classify (
	input irfc_pkg::frame_t fin,
	input logic [7:0] count,
	output irfc_pkg::result_t res
);
	import irfc_pkg::*;

	logic [9:0] thr;
	logic rc_len;

	assign thr = 10'((10'(count) * 10'd3) >> 2);
	assign rc_len = (count >= 8'd12) && (count <= 8'd40);

	always_comb begin
		res = '0;
		res.confidence = 7'd20;
		if (count >= 8'd3 && fin.flags[FRep]) begin
			res.protocol = ProtoRep; res.confidence = 7'd90; res.repeat_frame = 1'b1;
		end else if (count >= 8'd66 && fin.flags[FNec]) begin
			res.protocol = ProtoNec; res.bit_count = 6'd32; res.confidence = 7'd95;
			res.code_value = 48'(fin.nec_value);
		end else if (count >= 8'd66 && fin.flags[FSam]) begin
			res.protocol = ProtoSam; res.bit_count = 6'd32; res.confidence = 7'd88;
			res.code_value = 48'(fin.nec_value);
		end else if (count >= 8'd58 && fin.flags[FLg]) begin
			res.protocol = ProtoLg; res.bit_count = 6'd28; res.confidence = 7'd82;
			res.code_value = 48'(fin.nec_value[27:0]);
		end else if (count >= 8'd41 && fin.flags[FS20]) begin
			res.protocol = ProtoSony; res.bit_count = 6'd20; res.confidence = 7'd86;
			res.code_value = 48'(fin.sony_value);
		end else if (count >= 8'd31 && fin.flags[FS15]) begin
			res.protocol = ProtoSony; res.bit_count = 6'd15; res.confidence = 7'd86;
			res.code_value = 48'(fin.sony_value[14:0]);
		end else if (count >= 8'd25 && fin.flags[FS12]) begin
			res.protocol = ProtoSony; res.bit_count = 6'd12; res.confidence = 7'd86;
			res.code_value = 48'(fin.sony_value[11:0]);
		end else if (count >= 8'd98 && fin.flags[FPan]) begin
			res.protocol = ProtoPan; res.bit_count = 6'd48; res.confidence = 7'd78;
			res.code_value = fin.pan_value;
		end else if (rc_len && fin.flags[FRc6]) begin
			res.protocol = ProtoRc6; res.confidence = 7'd60;
		end else if (rc_len && 10'(fin.rc5_votes) >= thr) begin
			res.protocol = ProtoRc5; res.confidence = 7'd55;
		end
		res.decoded = (res.protocol != ProtoRaw);
	end
endmodule

FILE: hw/rtl/ir_remote_frame_classifier.sv
// The result is registered: it appears in the cycle after the last item of a frame is accepted.
// Throughput: one item per cycle while the input is not stalled; all candidate checks update in one pass of logic.
// The result register stalls input only while a result is held and not taken.
// Reset clears the frame state, the result valid and the registers to 30 and 160.
// Configuration writes are always accepted.
module ir_remote_frame_classifier (
	input logic clk,
	input logic arst_n,
	irfc_item_if.sink item,
	irfc_result_if.source result,
	irfc_cfg_if.sink cfg
);
	import irfc_pkg::*;
	`include "assert_macros.svh"

	logic [PctW-1:0] pct_q;
	logic [DurW-1:0] min_tol_q;
	frame_t frame_q, frame_nxt, frame_clr;
	result_t res_q, res_d;
	logic res_valid_q;
	logic accept;

	assign cfg.ready = 1'b1;
	assign item.ready = !res_valid_q || result.ready;
	assign accept = item.valid && item.ready;

	assign frame_clr = '{index: '0, flags: '1, nec_value: '0, pan_value: '0,
		sony_value: '0, rc5_votes: '0};

	irfc_check u_check (
		.d(item.duration_us), .pct(pct_q), .min_tol(min_tol_q),
		.cur(frame_q), .nxt(frame_nxt)
	);

	irfc_classify u_classify (
		.fin(frame_nxt), .count(8'(frame_q.index) + 8'd1), .res(res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= PctReset;
			min_tol_q <= MinTolReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				CfgPct: pct_q <= cfg.data[PctW-1:0];
				CfgMinTol: min_tol_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '{index: '0, flags: '1, nec_value: '0, pan_value: '0,
				sony_value: '0, rc5_votes: '0};
			res_valid_q <= 1'b0;
		end else begin
			if (accept) frame_q <= item.last ? frame_clr : frame_nxt;
			if (accept && item.last) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.last) res_q <= res_d;
	end

	assign result.valid = res_valid_q;
	assign result.protocol = res_q.protocol;
	assign result.code_value = res_q.code_value;
	assign result.bit_count = res_q.bit_count;
	assign result.confidence = res_q.confidence;
	assign result.decoded = res_q.decoded;
	assign result.repeat_frame = res_q.repeat_frame;

	`ASSERT_NEXT(a_last_gives_result, clk, arst_n, accept && item.last, result.valid)
	`ASSERT_NEXT(a_last_clears_frame, clk, arst_n, accept && item.last,
		frame_q.index == '0 && frame_q.flags == '1)
	`ASSERT_IMPL(a_decoded_matches, clk, arst_n, result.valid,
		result.decoded == (result.protocol != ProtoRaw))
endmodule

FILE: tb/tb_ir_remote_frame_classifier.sv
// Self-checking testbench of the IR remote frame classifier.
module tb_ir_remote_frame_classifier;
	timeunit 1ns;
	timeprecision 1ps;
	import irfc_pkg::*;

	typedef struct {
		logic [15:0] dur;
		logic last;
	} pulse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	irfc_item_if item ();
	irfc_result_if result ();
	irfc_cfg_if cfg ();

	ir_remote_frame_classifier dut (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source), .cfg(cfg.sink)
	);

	always #1 clk = ~clk;

	// Predictor copy of the classifier registers and frame state.
	int unsigned pct_cfg = 30;
	int unsigned mintol_cfg = 160;
	int unsigned pos;
	logic [8:0] alive;
	logic [31:0] nec_bits;
	logic [47:0] pan_bits;
	logic [19:0] sony_bits;
	int unsigned rc5_votes;

	pulse_t pending[$];
	result_t expected_results[$];
	int errors = 0;
	int send_idle_pct = 35;
	int recv_idle_pct = 80;
	bit recv_hold = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	bit item_fired = 1'b0;
	int stall_cycles = 0;
	int quiet_cycles = 0;

	function automatic bit in_window(int unsigned d, int unsigned tgt, int unsigned p);
		int unsigned tol;
		int unsigned lo;
		tol = (tgt * p) / 100;
		if (tol < mintol_cfg) tol = mintol_cfg;
		lo = (tgt > tol) ? tgt - tol : 0;
		return d >= lo && d <= tgt + tol;
	endfunction

	function automatic void clear_frame_state();
		pos = 0;
		alive = '1;
		nec_bits = '0;
		pan_bits = '0;
		sony_bits = '0;
		rc5_votes = 0;
	endfunction

	function automatic void kill(int f);
		alive[f] = 1'b0;
	endfunction

	// Pulse-distance body: marks on even positions, zero/one spaces on odd ones.
	function automatic bit distance_ok(int unsigned p, int unsigned d, int unsigned mark,
			int unsigned one_us, output bit is_one);
		is_one = 1'b0;
		if (p[0] == 1'b0) return in_window(d, mark, pct_cfg);
		is_one = in_window(d, one_us, pct_cfg);
		return is_one || in_window(d, mark, pct_cfg);
	endfunction

	function automatic void check_pulse(int unsigned p, int unsigned d);
		bit one;
		bit ok;
		if (p == 0) begin
			if (!in_window(d, 9000, pct_cfg)) begin kill(FRep); kill(FNec); kill(FLg); end
			if (!in_window(d, 4500, pct_cfg)) kill(FSam);
			if (!in_window(d, 2400, pct_cfg)) begin kill(FS20); kill(FS15); kill(FS12); end
			if (!in_window(d, 3500, pct_cfg)) kill(FPan);
			if (!in_window(d, 2666, 25)) kill(FRc6);
		end else if (p == 1) begin
			if (!in_window(d, 2250, pct_cfg)) kill(FRep);
			if (!in_window(d, 4500, pct_cfg)) begin kill(FNec); kill(FSam); end
			if (!in_window(d, 4200, pct_cfg)) kill(FLg);
			if (!in_window(d, 600, pct_cfg)) begin kill(FS20); kill(FS15); kill(FS12); end
			if (!in_window(d, 1750, pct_cfg)) kill(FPan);
			if (!in_window(d, 889, 30)) kill(FRc6);
		end else begin
			if (p == 2 && !in_window(d, 560, pct_cfg)) kill(FRep);
			if (p < 66) begin
				ok = distance_ok(p, d, 560, 1690, one);
				if (!ok) begin kill(FNec); kill(FSam); if (p < 58) kill(FLg); end
				if (one) nec_bits[((p - 3) >> 1) & 31] = 1'b1;
			end
			if (p < 98) begin
				ok = distance_ok(p, d, 430, 1290, one);
				if (!ok) kill(FPan);
				if (one) pan_bits[((p - 3) >> 1) % 48] = 1'b1;
			end
			if (p <= 40) begin
				if (p[0] == 1'b0) begin
					one = in_window(d, 1200, pct_cfg);
					ok = one || in_window(d, 600, pct_cfg);
					if (one) sony_bits[(p - 2) >> 1] = 1'b1;
				end else begin
					ok = in_window(d, 600, pct_cfg);
				end
				if (!ok) begin
					kill(FS20);
					if (p <= 30) kill(FS15);
					if (p <= 24) kill(FS12);
				end
			end
		end
		if (in_window(d, 889, 35) || in_window(d, 1778, 35))
			if (rc5_votes < 127) rc5_votes++;
	endfunction

	function automatic void classify_pulse(pulse_t it);
		int unsigned n;
		result_t r;
		if (pos < 127) check_pulse(pos, it.dur);
		if (!it.last) begin
			if (pos < 127) pos++;
			return;
		end
		n = pos + 1;
		r = '{protocol: ProtoRaw, code_value: '0, bit_count: 0, confidence: 20,
			decoded: 1'b0, repeat_frame: 1'b0};
		if (n >= 3 && alive[FRep]) begin
			r.protocol = ProtoRep; r.confidence = 90; r.repeat_frame = 1'b1;
		end else if (n >= 66 && alive[FNec]) begin
			r.protocol = ProtoNec; r.bit_count = 32; r.confidence = 95; r.code_value = nec_bits;
		end else if (n >= 66 && alive[FSam]) begin
			r.protocol = ProtoSam; r.bit_count = 32; r.confidence = 88; r.code_value = nec_bits;
		end else if (n >= 58 && alive[FLg]) begin
			r.protocol = ProtoLg; r.bit_count = 28; r.confidence = 82;
			r.code_value = nec_bits[27:0];
		end else if (n >= 41 && alive[FS20]) begin
			r.protocol = ProtoSony; r.bit_count = 20; r.confidence = 86; r.code_value = sony_bits;
		end else if (n >= 31 && alive[FS15]) begin
			r.protocol = ProtoSony; r.bit_count = 15; r.confidence = 86;
			r.code_value = sony_bits[14:0];
		end else if (n >= 25 && alive[FS12]) begin
			r.protocol = ProtoSony; r.bit_count = 12; r.confidence = 86;
			r.code_value = sony_bits[11:0];
		end else if (n >= 98 && alive[FPan]) begin
			r.protocol = ProtoPan; r.bit_count = 48; r.confidence = 78; r.code_value = pan_bits;
		end else if (n >= 12 && n <= 40 && alive[FRc6]) begin
			r.protocol = ProtoRc6; r.confidence = 60;
		end else if (n >= 12 && n <= 40 && rc5_votes >= (n * 3) / 4) begin
			r.protocol = ProtoRc5; r.confidence = 55;
		end
		r.decoded = (r.protocol != ProtoRaw);
		expected_results.push_back(r);
		clear_frame_state();
	endfunction

	// Driver: offers the head of the queue, idling at random, and drives a random result ready.
	always @(negedge clk) begin
		if (!arst_n) begin
			item.valid <= 1'b0;
			item.duration_us <= '0;
			item.last <= 1'b0;
			result.ready <= 1'b0;
		end else begin
			// The transaction flag comes from the last rising edge, not from the current ready.
			if (!item.valid || item_fired) begin
				if (item_fired) void'(pending.pop_front());
				if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item.valid <= 1'b1;
					item.duration_us <= pending[0].dur;
					item.last <= pending[0].last;
				end else begin
					item.valid <= 1'b0;
				end
			end
			result.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predicts on accepted items, checks accepted results.
	always @(posedge clk) begin
		result_t exp_r;
		item_fired <= arst_n && item.valid && item.ready;
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (item.valid && item.ready)
				classify_pulse('{dur: item.duration_us, last: item.last});
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction, protocol %0d", result.protocol);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (result.protocol !== exp_r.protocol) begin
						$error("protocol: expected %0d, got %0d", exp_r.protocol, result.protocol);
						errors++;
					end
					if (result.code_value !== exp_r.code_value) begin
						$error("code_value: expected %h, got %h", exp_r.code_value,
							result.code_value);
						errors++;
					end
					if (result.bit_count !== exp_r.bit_count) begin
						$error("bit_count: expected %0d, got %0d", exp_r.bit_count,
							result.bit_count);
						errors++;
					end
					if (result.confidence !== exp_r.confidence) begin
						$error("confidence: expected %0d, got %0d", exp_r.confidence,
							result.confidence);
						errors++;
					end
					if (result.decoded !== exp_r.decoded) begin
						$error("decoded: expected %0d, got %0d", exp_r.decoded, result.decoded);
						errors++;
					end
					if (result.repeat_frame !== exp_r.repeat_frame) begin
						$error("repeat_frame: expected %0d, got %0d", exp_r.repeat_frame,
							result.repeat_frame);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (quiet_cycles > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Long receiver hold-off so the result register fills and stalls the input.
	always @(posedge clk) begin
		if (recv_hold) begin
			if (stall_cycles >= 300) begin
				recv_hold <= 1'b0;
				stall_cycles <= 0;
				hold_done <= 1'b1;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end else if (hold_req && !hold_done) begin
			recv_hold <= 1'b1;
		end
	end

	function automatic int unsigned jitter(int unsigned us);
		int unsigned j;
		j = us / 8;
		return us - j + $urandom_range(2 * j);
	endfunction

	function automatic void add(int unsigned us, bit last);
		pending.push_back('{dur: us[15:0], last: last});
	endfunction

	// Pulse-distance frame with a header and nbits data bits.
	task automatic queue_distance(int unsigned h0, int unsigned h1, int unsigned mark,
			int unsigned one_us, int nbits, logic [47:0] code);
		add(jitter(h0), 1'b0);
		add(jitter(h1), 1'b0);
		for (int i = 0; i < nbits; i++) begin
			add(jitter(mark), 1'b0);
			add(jitter(code[i] ? one_us : mark), 1'b0);
		end
		add(jitter(mark), 1'b1);
	endtask

	task automatic queue_sony(int nbits, logic [19:0] code);
		add(jitter(2400), 1'b0);
		for (int i = 0; i < nbits; i++) begin
			add(jitter(600), 1'b0);
			add(jitter(code[i] ? 1200 : 600), i == nbits - 1);
		end
	endtask

	task automatic queue_rc(bit rc6, int n);
		for (int i = 0; i < n; i++) begin
			if (rc6 && i == 0) add(jitter(2666), n == 1);
			else if (rc6 && i == 1) add(jitter(889), n == 2);
			else add(jitter($urandom_range(1) ? 889 : 1778), i == n - 1);
		end
	endtask

	task automatic queue_noise(int n);
		for (int i = 0; i < n; i++)
			add($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(10000),
				i == n - 1);
	endtask

	task automatic queue_random_frame();
		logic [47:0] code;
		int sel;
		int nbits;
		code = 48'({$urandom, $urandom});
		sel = $urandom_range(11);
		case (sel)
			0: begin
				add(jitter(9000), 1'b0); add(jitter(2250), 1'b0); add(jitter(560), 1'b1);
			end
			1: queue_distance(9000, 4500, 560, 1690, 32, code);
			2: queue_distance(4500, 4500, 560, 1690, 32, code);
			3: queue_distance(9000, 4200, 560, 1690, 28, code);
			4: queue_sony(20, code[19:0]);
			5: queue_sony(15, code[19:0]);
			6: queue_sony(12, code[19:0]);
			7: queue_distance(3500, 1750, 430, 1290, 48, code);
			8: queue_rc(1'b1, $urandom_range(12, 40));
			9: queue_rc(1'b0, $urandom_range(1, 45));
			10: begin
				// Broken frame: a well-formed start cut short or corrupted.
				nbits = $urandom_range(1, 32);
				queue_distance(9000, 4500, 560, 1690, nbits, code);
				pending[pending.size() - 1 - $urandom_range(2 * nbits)].dur = 16'($urandom);
			end
			default: queue_noise($urandom_range(1, 140));
		endcase
	endtask

	task automatic wait_drained();
		while (pending.size() > 0 || item.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == CfgPct) pct_cfg = val[6:0];
		else mintol_cfg = val;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic run_random(int items);
		int target;
		target = pending.size() + items;
		while (pending.size() < target) queue_random_frame();
		wait_drained();
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.index = CfgPct;
		cfg.data = '0;
		clear_frame_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, short frames, repeat, both-window space, saturated count.
		add(16'hFFFF, 1'b1);
		add(0, 1'b1);
		add(9000, 1'b0); add(2250, 1'b0); add(560, 1'b1);
		add(9000, 1'b0); add(2250, 1'b1);
		queue_rc(1'b1, 12);
		queue_rc(1'b0, 12);
		wait_drained();
		write_reg(CfgPct, 16'd100);
		write_reg(CfgMinTol, 16'd600);
		queue_distance(9000, 4500, 560, 1690, 32, 48'hA5A5_1234_5678);
		queue_sony(12, 20'h5A5);
		wait_drained();
		write_reg(CfgPct, 16'd127);
		write_reg(CfgMinTol, 16'hFFFF);
		queue_noise(130);
		queue_noise(3);
		wait_drained();
		write_reg(CfgPct, 16'd0);
		write_reg(CfgMinTol, 16'd0);
		add(9000, 1'b0); add(2250, 1'b0); add(560, 1'b1);
		queue_noise(20);
		wait_drained();
		write_reg(CfgPct, 16'd30);
		write_reg(CfgMinTol, 16'd160);

		// Random phases with changing idling profiles.
		run_random(520);
		// Hold the receiver off while items keep coming, then let everything drain.
		hold_req = 1'b1;
		queue_random_frame();
		queue_random_frame();
		wait_drained();
		send_idle_pct = 80;
		recv_idle_pct = 35;
		write_reg(CfgPct, 16'd15);
		write_reg(CfgMinTol, 16'd100);
		run_random(520);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CfgPct, 16'($urandom_range(100)));
		write_reg(CfgMinTol, 16'($urandom_range(400)));
		run_random(520);

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/irfc_pkg.sv
hw/rtl/irfc_if.sv
hw/rtl/irfc_check.sv
hw/rtl/irfc_classify.sv
hw/rtl/ir_remote_frame_classifier.sv
tb/tb_ir_remote_frame_classifier.sv
